### src/swsd_pkg.sv
// shared types and constants for the sliding window standard deviation block
package swsd_pkg;

    // smallest window length a write may set
    localparam int MIN_WINDOW = 3;

    // register index of window_len in the configuration space
    localparam logic REG_WINDOW_LEN = 1'b0;

    // sequencer states, one-hot
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_RD    = 9'b000000010,
        ST_SQ    = 9'b000000100,
        ST_ACC   = 9'b000001000,
        ST_MUL   = 9'b000010000,
        ST_VAR   = 9'b000100000,
        ST_START = 9'b001000000,
        ST_DIV   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } swsd_state_t;

endpackage

### src/swsd_div.sv
// restoring divider, one quotient bit per cycle
module swsd_div
    import swsd_pkg::*;
#(
    parameter int N_W = 32,
    parameter int D_W = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           busy,
    output logic [N_W-1:0] quotient,
    output logic [D_W-1:0] remainder
);

    localparam int C_W = $clog2(N_W + 1);

    logic [N_W-1:0] quo_reg, quo_next;
    logic [D_W-1:0] rem_reg, rem_next;
    logic [D_W-1:0] den_reg, den_next;
    logic [C_W-1:0] cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic [D_W:0]   shift_val;
    logic [D_W:0]   sub_val;
    logic           fits;

    // trial subtraction of the divisor from the shifted remainder
    always_comb begin
        shift_val = {rem_reg, quo_reg[N_W-1]};
        sub_val   = shift_val - {1'b0, den_reg};
        fits      = (shift_val >= {1'b0, den_reg});
    end

    // next state of the iteration
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = C_W'(N_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[N_W-2:0], fits};
            rem_next = fits ? sub_val[D_W-1:0] : shift_val[D_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == C_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### src/swsd_sqrt.sv
// digit-by-digit integer square root, one root bit per cycle
module swsd_sqrt
    import swsd_pkg::*;
#(
    parameter int R_W = 23
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [2*R_W-1:0] radicand,
    output logic             busy,
    output logic [R_W-1:0]   root
);

    localparam int C_W = $clog2(R_W + 1);

    logic [2*R_W-1:0] x_reg, x_next;
    logic [R_W:0]     rem_reg, rem_next;
    logic [R_W-1:0]   root_reg, root_next;
    logic [C_W-1:0]   cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [R_W+2:0]   rem_shift;
    logic [R_W+2:0]   trial;
    logic [R_W+2:0]   sub_val;
    logic             fits;

    // bring down two radicand bits and try root*4+1
    always_comb begin
        rem_shift = {rem_reg, x_reg[2*R_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        sub_val   = rem_shift - trial;
        fits      = (rem_shift >= trial);
    end

    // next state of the iteration
    always_comb begin
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            x_next    = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = C_W'(R_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            x_next    = {x_reg[2*R_W-3:0], 2'b00};
            rem_next  = fits ? sub_val[R_W:0] : rem_shift[R_W:0];
            root_next = {root_reg[R_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == C_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

### src/sliding_window_std_dev.sv
// top level: sample ring memory, running sums, mean and standard deviation sequencer
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------------------------
//  s_       | in        | s_tvalid / s_tready       | s_tdata: sample
//  m_       | out       | m_tvalid / m_tready       | m_tdata: std_dev, mean, count_used
//  apb      | in        | psel, penable, pwrite     | paddr, pwdata, prdata (window_len)
//
//  the serial divider of the variance by n*n (one bit a cycle over the scaled variance)
//  and then the serial square root (one root bit a cycle) set how long one word takes.
//  the mean division runs beside the variance division and is hidden by it.
//  reset is synchronous; it empties the window and sets window_len to MAX_WINDOW.
//  a finished word waits in the output register; s_tready returns while it waits.
module sliding_window_std_dev
    import swsd_pkg::*;
#(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8,
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1),
    localparam int STD_W      = SAMPLE_BITS - 1 + FRAC_BITS,
    localparam int MEAN_W     = SAMPLE_BITS + FRAC_BITS,
    localparam int IN_W       = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_BITS   = STD_W + MEAN_W + CNT_W,
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    // sample [SAMPLE_BITS-1:0], zero fill above
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    // std_dev [STD_W-1:0], mean [MEAN_W], count_used [CNT_W], zero fill above
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
    localparam int SQ_W   = 2 * SAMPLE_BITS;
    localparam int Q_W    = 2 * SAMPLE_BITS - 1 + $clog2(MAX_WINDOW);
    localparam int VAR_W  = CNT_W + Q_W;
    localparam int VARS_W = VAR_W + 2 * FRAC_BITS;
    localparam int MN_W   = SUM_W + FRAC_BITS;
    localparam int NN_W   = 2 * CNT_W;

    // window length limited to the legal range
    function automatic logic [CNT_W-1:0] clamp_len(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = v;
        if (v < CNT_W'(MIN_WINDOW)) begin
            r = CNT_W'(MIN_WINDOW);
        end else if (v > CNT_W'(MAX_WINDOW)) begin
            r = CNT_W'(MAX_WINDOW);
        end
        return r;
    endfunction

    swsd_state_t state_reg, state_next;

    logic [CNT_W-1:0]              len_reg, len_next;
    logic [CNT_W-1:0]              fill_reg, fill_next;
    logic [ADDR_W-1:0]             pos_reg, pos_next;
    logic signed [SUM_W-1:0]       sum_reg, sum_next;
    logic [Q_W-1:0]                sqs_reg, sqs_next;
    logic                          ovalid_reg, ovalid_next;

    logic signed [SAMPLE_BITS-1:0] samp_reg;
    logic signed [SAMPLE_BITS-1:0] old_reg;
    logic [SQ_W-1:0]               sq_new_reg;
    logic [SQ_W-1:0]               sq_old_reg;
    logic [VAR_W-1:0]              nq_reg;
    logic [2*SUM_W-1:0]            ss_reg;
    logic [NN_W-1:0]               nn_reg;
    logic [VAR_W-1:0]              var_reg;
    logic [MN_W-1:0]               mag_reg;
    logic                          neg_reg;
    logic [MEAN_W-1:0]             mean_reg;
    logic [OUT_W-1:0]              odata_reg;

    logic [SAMPLE_BITS-1:0]        mem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0]        rd_data_reg;

    logic                          cfg_wr;
    logic                          full;
    logic [CNT_W-1:0]              pos_inc;
    logic                          div_start;
    logic                          sqrt_start;
    logic                          mdiv_busy;
    logic                          vdiv_busy;
    logic                          sqrt_busy;
    logic [MN_W-1:0]               mdiv_quo;
    logic [CNT_W-1:0]              mdiv_rem;
    logic [VARS_W-1:0]             vdiv_quo;
    logic [NN_W-1:0]               vdiv_rem;
    logic [STD_W-1:0]              std_root;
    logic signed [MN_W-1:0]        num_scaled;
    logic [MEAN_W-1:0]             mean_floor;
    logic                          divs_idle;

    // configuration port
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_LEN);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WINDOW_LEN) ? 32'(len_reg) : 32'd0;

    // ring bookkeeping
    assign full    = !(fill_reg < len_reg);
    assign pos_inc = CNT_W'(pos_reg) + 1'b1;

    // handshake
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    assign div_start  = (state_reg == ST_START);
    assign divs_idle  = !mdiv_busy && !vdiv_busy;
    assign sqrt_start = (state_reg == ST_DIV) && divs_idle;

    // floored mean from the magnitude quotient
    always_comb begin
        num_scaled = MN_W'(sum_reg) <<< FRAC_BITS;
        if (neg_reg) begin
            mean_floor = -MEAN_W'(mdiv_quo) - MEAN_W'(mdiv_rem != '0);
        end else begin
            mean_floor = MEAN_W'(mdiv_quo);
        end
    end

    // sequencer and running state
    always_comb begin
        state_next  = state_reg;
        len_next    = len_reg;
        fill_next   = fill_reg;
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        sqs_next    = sqs_reg;
        ovalid_next = ovalid_reg;
        if (ovalid_reg && m_tready) begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                if (full) begin
                    pos_next = (pos_inc >= len_reg) ? '0 : pos_inc[ADDR_W-1:0];
                end else begin
                    fill_next = fill_reg + 1'b1;
                end
                state_next = ST_SQ;
            end
            ST_SQ: begin
                sum_next   = sum_reg + SUM_W'(samp_reg) - SUM_W'(old_reg);
                state_next = ST_ACC;
            end
            ST_ACC: begin
                sqs_next   = sqs_reg + Q_W'(sq_new_reg) - Q_W'(sq_old_reg);
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_VAR;
            end
            ST_VAR: begin
                state_next = ST_START;
            end
            ST_START: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (divs_idle) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!sqrt_busy && (!ovalid_reg || m_tready)) begin
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // a window length write empties the window
        if (cfg_wr) begin
            len_next  = clamp_len(pwdata[CNT_W-1:0]);
            fill_next = '0;
            pos_next  = '0;
            sum_next  = '0;
            sqs_next  = '0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            len_reg    <= clamp_len(CNT_W'(MAX_WINDOW));
            fill_reg   <= '0;
            pos_reg    <= '0;
            sum_reg    <= '0;
            sqs_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            fill_reg   <= fill_next;
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            sqs_reg    <= sqs_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // sample memory: read the oldest entry on accept, write the new sample in the next cycle
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE) begin
            rd_data_reg <= mem[pos_reg];
        end
        if (state_reg == ST_RD) begin
            if (full) begin
                mem[pos_reg] <= samp_reg;
            end else begin
                mem[fill_reg[ADDR_W-1:0]] <= samp_reg;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE) begin
            samp_reg <= s_tdata[SAMPLE_BITS-1:0];
        end
        if (state_reg == ST_RD) begin
            old_reg <= full ? rd_data_reg : '0;
        end
        if (state_reg == ST_SQ) begin
            sq_new_reg <= SQ_W'(samp_reg) * SQ_W'(samp_reg);
            sq_old_reg <= SQ_W'(old_reg) * SQ_W'(old_reg);
        end
        if (state_reg == ST_MUL) begin
            nq_reg <= VAR_W'(fill_reg) * VAR_W'(sqs_reg);
            ss_reg <= (2 * SUM_W)'(sum_reg) * (2 * SUM_W)'(sum_reg);
            nn_reg <= NN_W'(fill_reg) * NN_W'(fill_reg);
        end
        if (state_reg == ST_VAR) begin
            var_reg <= nq_reg - VAR_W'(ss_reg);
            neg_reg <= sum_reg[SUM_W-1];
            mag_reg <= sum_reg[SUM_W-1] ? -num_scaled : num_scaled;
        end
        if (sqrt_start) begin
            mean_reg <= mean_floor;
        end
        if ((state_reg == ST_OUT) && !sqrt_busy && (!ovalid_reg || m_tready)) begin
            odata_reg <= OUT_W'({fill_reg, mean_reg, std_root});
        end
    end

    // mean: |S * 2^FRAC_BITS| / n
    swsd_div #(
        .N_W (MN_W),
        .D_W (CNT_W)
    ) u_mean_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (mag_reg),
        .divisor   (fill_reg),
        .busy      (mdiv_busy),
        .quotient  (mdiv_quo),
        .remainder (mdiv_rem)
    );

    // variance: (n*Q - S*S) * 2^(2*FRAC_BITS) / (n*n)
    swsd_div #(
        .N_W (VARS_W),
        .D_W (NN_W)
    ) u_var_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (VARS_W'(var_reg) << (2 * FRAC_BITS)),
        .divisor   (nn_reg),
        .busy      (vdiv_busy),
        .quotient  (vdiv_quo),
        .remainder (vdiv_rem)
    );

    // standard deviation
    swsd_sqrt #(
        .R_W (STD_W)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (vdiv_quo[2*STD_W-1:0]),
        .busy     (sqrt_busy),
        .root     (std_root)
    );

endmodule

### src/swsd_checker.sv
// port-level checks for the sliding window standard deviation block, bound to the top level
module swsd_checker
    import swsd_pkg::*;
#(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8,
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1),
    localparam int STD_W      = SAMPLE_BITS - 1 + FRAC_BITS,
    localparam int MEAN_W     = SAMPLE_BITS + FRAC_BITS,
    localparam int IN_W       = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_BITS   = STD_W + MEAN_W + CNT_W,
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
    input logic             aclk,
    input logic             aresetn,
    input logic [IN_W-1:0]  s_tdata,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic             psel,
    input logic             penable,
    input logic             pwrite,
    input logic [2:0]       paddr,
    input logic [31:0]      pwdata,
    input logic [31:0]      prdata,
    input logic             pready
);

    logic [CNT_W-1:0] out_count;
    logic [STD_W-1:0] out_std;

    assign out_count = m_tdata[STD_W+MEAN_W +: CNT_W];
    assign out_std   = m_tdata[STD_W-1:0];

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one word at a time: input closes after an accept
    a_in_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word accepted while one is in work");

    // count in use lies between one and the maximum window
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_count != '0) && (out_count <= CNT_W'(MAX_WINDOW)))
        else $error("count_used out of range");

    // a single sample has no spread
    a_single_std: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_count == CNT_W'(1)) |-> (out_std == '0))
        else $error("nonzero std_dev with one sample held");

    // accesses complete without wait states
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable |-> pready)
        else $error("configuration access stalled");

endmodule

bind sliding_window_std_dev swsd_checker #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
) u_swsd_checker (.*);

### tb/sliding_window_std_dev_test.sv
// testbench for the sliding window mean and standard deviation block
module sliding_window_std_dev_test;
    import swsd_pkg::*;

    localparam int         WIN_MAX   = 64;
    localparam logic [2:0] ADDR_WLEN = 3'd0;   // window_len register
    localparam logic [2:0] ADDR_NONE = 3'd4;   // no register behind this address

    typedef struct packed {
        logic [22:0]        std_dev;
        logic signed [23:0] mean;
        logic [6:0]         count_used;
    } window_stats_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    // sample [15:0]
    logic [15:0] s_tdata  = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // std_dev [22:0], mean [46:23], count_used [53:47], zero fill [55:54]
    logic [55:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // window model state
    logic signed [15:0]  ring_samples [WIN_MAX];
    int                  win_len    = WIN_MAX;
    int                  held_count = 0;
    int                  ring_pos   = 0;
    longint              run_sum    = 0;
    longint unsigned     run_sq_sum = 0;

    window_stats_t expected_stats [$];
    int errors      = 0;
    int burst_left  = 0;
    int tx_gappy    = 0;
    int rx_mode     = 0;
    int rx_stall    = 0;
    int hold_left   = 0;

    sliding_window_std_dev u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #2000000;
        $display("sliding_window_std_dev regression: fail");
        $finish;
    end

    // floored square root, one root bit per step from the top
    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= x)
                root = trial;
        end
        return root;
    endfunction

    // take one sample into the window and work out the statistics word
    function automatic window_stats_t absorb_sample(logic signed [15:0] smp);
        window_stats_t   res;
        longint          oldest;
        longint          n;
        longint          scaled;
        longint          quot;
        longint unsigned spread;
        if (held_count < win_len) begin
            ring_samples[held_count] = smp;
            held_count++;
            run_sum    += smp;
            run_sq_sum += longint'(smp) * longint'(smp);
        end else begin
            oldest = ring_samples[ring_pos];
            run_sum    += longint'(smp) - oldest;
            run_sq_sum  = run_sq_sum + longint'(smp) * longint'(smp) - oldest * oldest;
            ring_samples[ring_pos] = smp;
            ring_pos = (ring_pos + 1 >= win_len) ? 0 : ring_pos + 1;
        end
        n      = held_count;
        scaled = run_sum * 256;
        quot   = scaled / n;
        // round toward minus infinity
        if ((scaled % n) != 0 && scaled < 0)
            quot--;
        spread = longint'(n) * run_sq_sum - longint'(run_sum * run_sum);
        spread = (spread * 65536) / longint'(n * n);
        res.std_dev    = 23'(floor_sqrt(spread));
        res.mean       = 24'(quot);
        res.count_used = 7'(n);
        return res;
    endfunction

    // outputs are checked before new inputs are predicted at the same edge
    always @(posedge aclk) begin
        window_stats_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_stats.size() == 0) begin
                    $error("unexpected result word %h", m_tdata);
                    errors++;
                end else begin
                    want = expected_stats.pop_front();
                    if (m_tdata[22:0] !== want.std_dev) begin
                        $error("std_dev: expected %0d, got %0d", want.std_dev, m_tdata[22:0]);
                        errors++;
                    end
                    if (m_tdata[46:23] !== want.mean) begin
                        $error("mean: expected %0d, got %0d",
                               want.mean, $signed(m_tdata[46:23]));
                        errors++;
                    end
                    if (m_tdata[53:47] !== want.count_used) begin
                        $error("count_used: expected %0d, got %0d",
                               want.count_used, m_tdata[53:47]);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_stats.push_back(absorb_sample(s_tdata));
        end
    end

    // receiver: long hold-off when asked, otherwise the current stall pattern
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            case (rx_mode)
                0: begin
                    m_tready <= 1'b1;
                end
                1: begin
                    m_tready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    if (rx_stall > 0) begin
                        m_tready <= 1'b0;
                        rx_stall--;
                    end else begin
                        m_tready <= 1'b1;
                        if ($urandom_range(0, 7) == 0)
                            rx_stall = $urandom_range(1, 12);
                    end
                end
            endcase
        end
    end

    // offer one word, with bursts and gaps when the sender is gappy
    task automatic send_sample(input logic signed [15:0] smp);
        int gap;
        if (burst_left == 0) begin
            burst_left = tx_gappy ? $urandom_range(1, 8) : 1000;
            gap        = tx_gappy ? $urandom_range(0, 20) : 0;
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    // register write, setup then access phase
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        int idx;
        int len;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        idx = int'(addr[2]);
        if (idx == REG_WINDOW_LEN) begin
            len = int'(data[6:0]);
            win_len    = (len < MIN_WINDOW) ? MIN_WINDOW : (len > WIN_MAX) ? WIN_MAX : len;
            held_count = 0;
            ring_pos   = 0;
            run_sum    = 0;
            run_sq_sum = 0;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stop offering and let every expected word come out
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid   <= 1'b0;
        burst_left = 0;
        wait (expected_stats.size() == 0);
        repeat (8) @(posedge aclk);
    endtask

    function automatic logic signed [15:0] random_sample();
        case ($urandom_range(0, 9))
            0, 1: begin
                case ($urandom_range(0, 3))
                    0: return -16'sd32768;
                    1: return 16'sd32767;
                    2: return 16'sd0;
                    default: return -16'sd1;
                endcase
            end
            2, 3: return $signed(16'($urandom_range(0, 31))) - 16'sd16;
            default: return 16'($urandom);
        endcase
    endfunction

    // reset length, first sample alone and the field extremes
    task automatic test_first_samples();
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        wait_idle();
    endtask

    // window left at its reset length fills and then wraps
    task automatic test_reset_length_wrap();
        tx_gappy = 1;
        rx_mode  = 2;
        repeat (75) send_sample(random_sample());
        wait_idle();
    endtask

    // shortest window with extremes, clamped lengths and the empty address
    task automatic test_length_limits();
        tx_gappy = 0;
        rx_mode  = 0;
        write_reg(ADDR_WLEN, 32'd3);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(16'sd32767);
        wait_idle();
        write_reg(ADDR_WLEN, 32'd0);
        send_sample(16'sd5);
        send_sample(-16'sd7);
        send_sample(16'sd9);
        send_sample(16'sd11);
        wait_idle();
        write_reg(ADDR_WLEN, 32'd2);
        write_reg(ADDR_NONE, 32'd10);
        send_sample(16'sd100);
        send_sample(-16'sd100);
        send_sample(16'sd100);
        send_sample(16'sd3);
        wait_idle();
        write_reg(ADDR_WLEN, 32'd127);
        send_sample(16'sd1);
        send_sample(-16'sd2);
        wait_idle();
    endtask

    // random lengths and samples with changing flow patterns
    task automatic test_random_windows();
        int          sent;
        int          phase_items;
        logic [31:0] len_word;
        sent = 0;
        for (int phase = 0; sent < 1300; phase++) begin
            case (phase % 6)
                0: len_word = 32'd64;
                1: len_word = 32'd3;
                2: len_word = $urandom_range(0, 127);
                3: len_word = $urandom_range(65, 127);
                4: len_word = {$urandom_range(0, 1) ? 25'($urandom) : 25'd0,
                               7'($urandom_range(3, 64))};
                default: len_word = $urandom_range(3, 16);
            endcase
            write_reg(ADDR_WLEN, len_word);
            tx_gappy    = $urandom_range(0, 1);
            rx_mode     = $urandom_range(0, 2);
            phase_items = $urandom_range(40, 160);
            repeat (phase_items) send_sample(random_sample());
            sent += phase_items;
            wait_idle();
        end
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_output_hold();
        write_reg(ADDR_WLEN, 32'd8);
        tx_gappy  = 0;
        rx_mode   = 0;
        hold_left = 600;
        repeat (12) send_sample(random_sample());
        wait_idle();
    endtask

    initial begin
        foreach (ring_samples[i]) ring_samples[i] = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_first_samples();
        test_reset_length_wrap();
        test_length_limits();
        test_random_windows();
        test_output_hold();
        if (errors == 0)
            $display("sliding_window_std_dev regression: pass");
        else
            $display("sliding_window_std_dev regression: fail");
        $finish;
    end

endmodule
